[sv/assert_macros.svh]
// Assertion macros shared by the checker modules.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check that prop holds in the cycle after cond, outside reset.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

[sv/wsd_pkg.sv]
// Shared constants, codes and types of the work-stealing deque.
// No dependencies.
`timescale 1ns / 1ps

package wsd_pkg;

   localparam int CAPACITY    = 256;
   localparam int SLOT_BITS   = $clog2(CAPACITY);
   localparam int INDEX_BITS  = SLOT_BITS + 1;
   localparam int COUNT_BITS  = INDEX_BITS;
   localparam int HANDLE_BITS = 64;
   localparam int FUNC_BITS   = 2;
   localparam int STATUS_BITS = 2;

   // operation codes
   localparam logic [FUNC_BITS-1:0] FUNC_PUSH  = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_POP   = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_STEAL = 2'd2;

   // result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

   // decoded operation from the index unit
   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [COUNT_BITS-1:0]  count_after;
      logic                   wr_en;
      logic                   rd_en;
      logic [SLOT_BITS-1:0]   addr;
   } wsd_op_type;

endpackage

[sv/work_stealing_deque.sv]
// Top level of the work-stealing deque: handshakes, ring RAM and result register.
// Depends on wsd_pkg, wsd_index_unit and wsd_ring_ram.
`timescale 1ns / 1ps

// Bounded task deque of wsd_pkg::CAPACITY handles in a ring RAM. The owner
// pushes (func 0) and pops (func 1) at the bottom; a thief steals (func 2) at
// the top. Each request beat yields exactly one response beat carrying status,
// the removed handle (zero unless a pop or steal succeeded) and the entry count
// after the operation. The ring RAM read and the decode are captured at the
// accepting edge and the response register loads from them once it is free.
// The indices update at acceptance, so a new request is taken every cycle
// while the response side keeps up: sustained rate is one item per cycle,
// and req_stall rises only while a finished response waits under rsp_stall
// with another already read from the RAM. No clearing pass runs after reset.
module work_stealing_deque (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [wsd_pkg::FUNC_BITS-1:0]   req_func,
   input  logic [wsd_pkg::HANDLE_BITS-1:0] req_task_handle,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [wsd_pkg::STATUS_BITS-1:0] rsp_status,
   output logic [wsd_pkg::HANDLE_BITS-1:0] rsp_handle_out,
   output logic [wsd_pkg::COUNT_BITS-1:0]  rsp_entry_count
);

   wsd_pkg::wsd_op_type op;

   logic                            accept;
   logic                            out_free;
   logic                            load;
   logic [wsd_pkg::HANDLE_BITS-1:0] rd_data;

   logic                            busy_ff, busy_in;
   logic [wsd_pkg::STATUS_BITS-1:0] pend_status_ff;
   logic [wsd_pkg::COUNT_BITS-1:0]  pend_count_ff;
   logic                            pend_take_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [wsd_pkg::STATUS_BITS-1:0] rsp_status_ff;
   logic [wsd_pkg::HANDLE_BITS-1:0] rsp_handle_ff;
   logic [wsd_pkg::COUNT_BITS-1:0]  rsp_count_ff;

   // handshake control
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign load         = busy_ff && out_free;
   assign req_stall    = busy_ff && !out_free;
   assign accept       = req_valid && !req_stall;
   assign busy_in      = accept || (busy_ff && !load);
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   wsd_index_unit u_index (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .func   (req_func),
      .op     (op)
   );

   wsd_ring_ram #(
      .ADDR_BITS (wsd_pkg::SLOT_BITS),
      .DATA_BITS (wsd_pkg::HANDLE_BITS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept && op.wr_en),
      .wr_addr (op.addr),
      .wr_data (req_task_handle),
      .rd_en   (accept && op.rd_en),
      .rd_addr (op.addr),
      .rd_data (rd_data)
   );

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the decoded result while the RAM read is in flight
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_status_ff <= op.status;
         pend_count_ff  <= op.count_after;
         pend_take_ff   <= op.rd_en;
      end
   end

   // load the response register once it is free
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_count_ff  <= pend_count_ff;
         rsp_handle_ff <= pend_take_ff ? rd_data : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_handle_out  = rsp_handle_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

[sv/wsd_ring_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wsd_ring_ram #(
   parameter int ADDR_BITS = 8,
   parameter int DATA_BITS = 64
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem_ff [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/wsd_index_unit.sv]
// Top and bottom index registers and the operation decode of the deque.
// Depends on wsd_pkg.
`timescale 1ns / 1ps

module wsd_index_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [wsd_pkg::FUNC_BITS-1:0] func,
   output wsd_pkg::wsd_op_type           op
);

   logic [wsd_pkg::INDEX_BITS-1:0] top_ff, top_in;
   logic [wsd_pkg::INDEX_BITS-1:0] bottom_ff, bottom_in;
   logic [wsd_pkg::INDEX_BITS-1:0] count;
   logic [wsd_pkg::INDEX_BITS-1:0] last;
   logic                           full;
   logic                           empty;

   assign count = bottom_ff - top_ff;
   assign last  = bottom_ff - wsd_pkg::INDEX_BITS'(1);
   assign full  = count >= wsd_pkg::INDEX_BITS'(wsd_pkg::CAPACITY);
   assign empty = count == '0;

   // decode the operation against the current indices
   always_comb begin
      top_in    = top_ff;
      bottom_in = bottom_ff;
      op.status = wsd_pkg::STATUS_EMPTY;
      op.wr_en  = 1'b0;
      op.rd_en  = 1'b0;
      op.addr   = bottom_ff[wsd_pkg::SLOT_BITS-1:0];
      unique case (func)
         wsd_pkg::FUNC_PUSH: begin
            if (full) begin
               op.status = wsd_pkg::STATUS_FULL;
            end else begin
               op.status = wsd_pkg::STATUS_OK;
               op.wr_en  = 1'b1;
               bottom_in = bottom_ff + wsd_pkg::INDEX_BITS'(1);
            end
         end
         wsd_pkg::FUNC_POP: begin
            op.addr = last[wsd_pkg::SLOT_BITS-1:0];
            if (!empty) begin
               op.status = wsd_pkg::STATUS_OK;
               op.rd_en  = 1'b1;
               // last entry leaves by the top so both indices meet
               if (count == wsd_pkg::INDEX_BITS'(1)) begin
                  top_in = top_ff + wsd_pkg::INDEX_BITS'(1);
               end else begin
                  bottom_in = last;
               end
            end
         end
         wsd_pkg::FUNC_STEAL: begin
            op.addr = top_ff[wsd_pkg::SLOT_BITS-1:0];
            if (!empty) begin
               op.status = wsd_pkg::STATUS_OK;
               op.rd_en  = 1'b1;
               top_in    = top_ff + wsd_pkg::INDEX_BITS'(1);
            end
         end
         default: begin
            op.status = wsd_pkg::STATUS_EMPTY;
         end
      endcase
      op.count_after = bottom_in - top_in;
   end

   // advance the indices on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff    <= '0;
         bottom_ff <= '0;
      end else if (accept) begin
         top_ff    <= top_in;
         bottom_ff <= bottom_in;
      end
   end

endmodule

[sv/wsd_checker.sv]
// Port-level checks of the work-stealing deque, bound to the top level.
// Depends on wsd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wsd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [wsd_pkg::STATUS_BITS-1:0] rsp_status,
   input logic [wsd_pkg::HANDLE_BITS-1:0] rsp_handle_out,
   input logic [wsd_pkg::COUNT_BITS-1:0]  rsp_entry_count
);

   // a stalled response beat keeps its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_handle_out) && $stable(rsp_entry_count))

   // failed operations never hand out a task
   `ASSERT_CLK(a_fail_no_handle, clock, reset, !(rsp_valid && rsp_status != wsd_pkg::STATUS_OK) || rsp_handle_out == '0)

   // a full report means the ring is at capacity
   `ASSERT_CLK(a_full_count, clock, reset, !(rsp_valid && rsp_status == wsd_pkg::STATUS_FULL) || rsp_entry_count == wsd_pkg::COUNT_BITS'(wsd_pkg::CAPACITY))

   // the count never exceeds capacity
   `ASSERT_CLK(a_count_range, clock, reset, !rsp_valid || rsp_entry_count <= wsd_pkg::COUNT_BITS'(wsd_pkg::CAPACITY))

endmodule

bind work_stealing_deque wsd_checker u_wsd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_handle_out  (rsp_handle_out),
   .rsp_entry_count (rsp_entry_count)
);

[tb/sv/tb.sv]
// Self-checking testbench for the work-stealing deque: push, owner pop and steal traffic.
// Depends on wsd_pkg and work_stealing_deque.
`timescale 1ns / 1ps

module tb;

   typedef struct packed {
      logic [wsd_pkg::STATUS_BITS-1:0] status;
      logic [wsd_pkg::HANDLE_BITS-1:0] handle;
      logic [wsd_pkg::COUNT_BITS-1:0]  count;
   } deque_rsp_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [wsd_pkg::FUNC_BITS-1:0]   req_func;
   logic [wsd_pkg::HANDLE_BITS-1:0] req_task_handle;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [wsd_pkg::STATUS_BITS-1:0] rsp_status;
   logic [wsd_pkg::HANDLE_BITS-1:0] rsp_handle_out;
   logic [wsd_pkg::COUNT_BITS-1:0]  rsp_entry_count;

   // mirror of the deque contents and indices
   logic [wsd_pkg::HANDLE_BITS-1:0] ring_mirror [wsd_pkg::CAPACITY];
   logic [wsd_pkg::INDEX_BITS-1:0]  top_ptr;
   logic [wsd_pkg::INDEX_BITS-1:0]  bot_ptr;

   deque_rsp_type pending_rsp [$];
   int            error_count;
   bit            req_idle_on;
   bit            rsp_idle_on;
   int            stall_left;

   work_stealing_deque dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_task_handle (req_task_handle),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_handle_out  (rsp_handle_out),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #400000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [wsd_pkg::COUNT_BITS-1:0] held_entries();
      return wsd_pkg::COUNT_BITS'(bot_ptr - top_ptr);
   endfunction

   // apply one operation to the mirror and return the response it produces
   function automatic deque_rsp_type deque_apply(
      input logic [wsd_pkg::FUNC_BITS-1:0]   f,
      input logic [wsd_pkg::HANDLE_BITS-1:0] h);
      deque_rsp_type                   r;
      logic [wsd_pkg::COUNT_BITS-1:0]  cnt;
      logic [wsd_pkg::INDEX_BITS-1:0]  last;
      cnt      = held_entries();
      r.status = wsd_pkg::STATUS_EMPTY;
      r.handle = '0;
      case (f)
         wsd_pkg::FUNC_PUSH: begin
            if (cnt >= wsd_pkg::CAPACITY) begin
               r.status = wsd_pkg::STATUS_FULL;
            end else begin
               ring_mirror[bot_ptr[wsd_pkg::SLOT_BITS-1:0]] = h;
               bot_ptr  = bot_ptr + 1'b1;
               r.status = wsd_pkg::STATUS_OK;
            end
         end
         wsd_pkg::FUNC_POP: begin
            if (cnt != 0) begin
               last     = bot_ptr - 1'b1;
               r.handle = ring_mirror[last[wsd_pkg::SLOT_BITS-1:0]];
               // taking the last entry moves top, otherwise bottom steps back
               if (cnt == 1) top_ptr = top_ptr + 1'b1;
               else bot_ptr = last;
               r.status = wsd_pkg::STATUS_OK;
            end
         end
         wsd_pkg::FUNC_STEAL: begin
            if (cnt != 0) begin
               r.handle = ring_mirror[top_ptr[wsd_pkg::SLOT_BITS-1:0]];
               top_ptr  = top_ptr + 1'b1;
               r.status = wsd_pkg::STATUS_OK;
            end
         end
         default: ;
      endcase
      r.count = held_entries();
      return r;
   endfunction

   function automatic logic [wsd_pkg::HANDLE_BITS-1:0] rand_handle();
      return {$urandom(), $urandom()};
   endfunction

   // send one request beat, with an optional idle burst in front
   task automatic send_beat(input logic [wsd_pkg::FUNC_BITS-1:0]   f,
                            input logic [wsd_pkg::HANDLE_BITS-1:0] h);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= f;
      req_task_handle <= h;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.push_back(deque_apply(f, h));
      @(negedge clock);
   endtask

   // random operation with a given push weight in percent
   task automatic send_random_op(input int push_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < push_pct) send_beat(wsd_pkg::FUNC_PUSH, rand_handle());
      else if (roll[0]) send_beat(wsd_pkg::FUNC_POP, rand_handle());
      else send_beat(wsd_pkg::FUNC_STEAL, rand_handle());
   endtask

   // check every response beat against the oldest prediction
   always @(posedge clock) begin
      deque_rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("response beat with no request outstanding");
            error_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_status !== exp_rsp.status) begin
               $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_status);
               error_count++;
            end
            if (rsp_handle_out !== exp_rsp.handle) begin
               $error("handle_out: expected %h, actual %h", exp_rsp.handle, rsp_handle_out);
               error_count++;
            end
            if (rsp_entry_count !== exp_rsp.count) begin
               $error("entry_count: expected %0d, actual %0d", exp_rsp.count,
                      rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   // response-side stall in short bursts
   always @(negedge clock) begin
      if (!rsp_idle_on) begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(1, 3);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // pop and steal on the empty queue after reset
   task automatic test_empty_queue();
      send_beat(wsd_pkg::FUNC_POP, rand_handle());
      send_beat(wsd_pkg::FUNC_STEAL, rand_handle());
   endtask

   // handle extremes through push, pop of the last entry and steal
   task automatic test_handle_extremes();
      send_beat(wsd_pkg::FUNC_PUSH, '0);
      send_beat(wsd_pkg::FUNC_PUSH, '1);
      send_beat(wsd_pkg::FUNC_POP, '0);
      send_beat(wsd_pkg::FUNC_POP, '1);
      send_beat(wsd_pkg::FUNC_PUSH, {wsd_pkg::HANDLE_BITS/4{4'hA}});
      send_beat(wsd_pkg::FUNC_PUSH, {wsd_pkg::HANDLE_BITS/4{4'h5}});
      send_beat(wsd_pkg::FUNC_STEAL, '0);
      send_beat(wsd_pkg::FUNC_STEAL, '0);
      send_beat(wsd_pkg::FUNC_STEAL, '1);
   endtask

   // owner side sees LIFO order, thief side sees FIFO order
   task automatic test_lifo_and_fifo();
      repeat (4) send_beat(wsd_pkg::FUNC_PUSH, rand_handle());
      send_beat(wsd_pkg::FUNC_POP, rand_handle());
      send_beat(wsd_pkg::FUNC_STEAL, rand_handle());
      send_beat(wsd_pkg::FUNC_POP, rand_handle());
      send_beat(wsd_pkg::FUNC_POP, rand_handle());
      send_beat(wsd_pkg::FUNC_POP, rand_handle());
      send_beat(wsd_pkg::FUNC_STEAL, rand_handle());
   endtask

   // fill to capacity, push against full, then drain from both ends
   task automatic test_fill_and_drain();
      while (held_entries() < wsd_pkg::CAPACITY) send_beat(wsd_pkg::FUNC_PUSH, rand_handle());
      repeat (3) send_beat(wsd_pkg::FUNC_PUSH, rand_handle());
      while (held_entries() != 0) begin
         if ($urandom_range(0, 1)) send_beat(wsd_pkg::FUNC_POP, rand_handle());
         else send_beat(wsd_pkg::FUNC_STEAL, rand_handle());
      end
      send_beat(wsd_pkg::FUNC_POP, rand_handle());
      send_beat(wsd_pkg::FUNC_STEAL, rand_handle());
   endtask

   // segments of mixed traffic with shifting push weight
   task automatic test_random_mix(input int beats);
      int sent;
      int seg_len;
      int push_pct;
      sent = 0;
      while (sent < beats) begin
         seg_len = $urandom_range(20, 60);
         case ($urandom_range(0, 2))
            0: push_pct = 20;
            1: push_pct = 50;
            default: push_pct = 85;
         endcase
         repeat (seg_len) send_random_op(push_pct);
         sent += seg_len;
      end
   endtask

   // back-to-back traffic with no idling on either side
   task automatic test_full_rate(input int beats);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (beats / 2) send_random_op(60);
      repeat (beats - beats / 2) send_random_op(40);
   endtask

   initial begin
      int guard;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = wsd_pkg::FUNC_PUSH;
      req_task_handle = '0;
      rsp_stall       = 1'b0;
      stall_left      = 0;
      error_count     = 0;
      top_ptr         = '0;
      bot_ptr         = '0;
      req_idle_on     = 1'b1;
      rsp_idle_on     = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_queue();
      test_handle_extremes();
      test_lifo_and_fifo();
      test_fill_and_drain();
      test_random_mix(450);
      test_full_rate(150);

      // drop valid and wait for the last responses
      req_valid <= 1'b0;
      guard = 0;
      while (pending_rsp.size() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $error("%0d responses never arrived", pending_rsp.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
